// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL core module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcaa_pkg.sv =====
// Shared types, constants and calibration table for the thermistor converter.
`default_nettype none

package tcaa_pkg;

    localparam int RAW_W         = 10;
    localparam int TEMP_W        = 8;
    localparam int ALU_W         = 10;
    localparam int TABLE_ENTRIES = 33;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int STEP_C        = 5;

    typedef logic signed [TEMP_W-1:0] t_temp;

    localparam t_temp T_UNDER  = -8'sd41;
    localparam t_temp T_OVER   = 8'sd121;
    localparam t_temp T_BASE   = -8'sd40;
    localparam t_temp MIN_INIT = 8'sd121;
    localparam t_temp MAX_INIT = -8'sd121;

    // Falling calibration curve: code at -40 C, -35 C, ... 120 C.
    localparam logic [RAW_W-1:0] CAL_POINTS [TABLE_ENTRIES] = '{
        10'd499, 10'd495, 10'd491, 10'd486, 10'd480, 10'd474, 10'd464, 10'd456,
        10'd443, 10'd431, 10'd419, 10'd407, 10'd392, 10'd380, 10'd368, 10'd356,
        10'd343, 10'd333, 10'd325, 10'd317, 10'd308, 10'd302, 10'd296, 10'd292,
        10'd286, 10'd282, 10'd280, 10'd276, 10'd274, 10'd272, 10'd270, 10'd268,
        10'd265
    };

    typedef struct packed {
        logic [ALU_W-1:0] diff;
        logic             ge;
    } t_alu_res;

    typedef struct packed {
        logic upd;
        logic clr;
    } t_acc_ctl;

    // Code distance between point idx-1 and point idx.
    function automatic logic [ALU_W-1:0] cal_span(input logic [IDX_W-1:0] idx);
        logic [ALU_W-1:0] span;
        span = '0;
        if (idx != '0) begin
            span = ALU_W'(CAL_POINTS[idx - IDX_W'(1)] - CAL_POINTS[idx]);
        end
        return span;
    endfunction

    // Temperature at table point idx.
    function automatic t_temp base_temp(input logic [IDX_W-1:0] idx);
        int v;
        v = int'(T_BASE) + STEP_C * int'(idx);
        return TEMP_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tcaa_if.sv =====
// Valid/ready channel interfaces for readings in and temperatures out.
`default_nettype none

interface tcaa_in_if;
    logic                       valid;
    logic                       ready;
    logic [tcaa_pkg::RAW_W-1:0] raw_reading;
    logic                       last_channel;

    modport source (output valid, output raw_reading, output last_channel, input ready);
    modport sink   (input valid, input raw_reading, input last_channel, output ready);
endinterface

interface tcaa_out_if;
    logic            valid;
    logic            ready;
    tcaa_pkg::t_temp temperature;
    logic            group_done;
    tcaa_pkg::t_temp lowest;
    tcaa_pkg::t_temp highest;
    tcaa_pkg::t_temp average;
    logic            none_in_range;

    modport source (output valid, output temperature, output group_done, output lowest,
                    output highest, output average, output none_in_range, input ready);
    modport sink   (input valid, input temperature, input group_done, input lowest,
                    input highest, input average, input none_in_range, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcaa_alu.sv =====
// Shared subtract/compare unit used by table search, interpolation and averaging.
`default_nettype none

module tcaa_alu (
    input  logic [tcaa_pkg::ALU_W-1:0] i_a,
    input  logic [tcaa_pkg::ALU_W-1:0] i_b,
    output tcaa_pkg::t_alu_res         o_res
);
    import tcaa_pkg::*;

    logic [ALU_W:0] sub;

    assign sub        = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.diff = sub[ALU_W-1:0];
    assign o_res.ge   = ~sub[ALU_W];

endmodule

`default_nettype wire

// ===== rtl/tcaa_acc.sv =====
// Group accumulators: running minimum, maximum, in-range sum and count.
`default_nettype none

module tcaa_acc #(
    parameter  int CHANNELS = 7,
    localparam int CNT_W    = $clog2(CHANNELS + 1),
    localparam int SUM_W    = CNT_W + tcaa_pkg::TEMP_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tcaa_pkg::t_acc_ctl      i_ctl,
    input  tcaa_pkg::t_temp         i_temp,
    output tcaa_pkg::t_temp         o_min,
    output tcaa_pkg::t_temp         o_max,
    output logic signed [SUM_W-1:0] o_sum,
    output logic [CNT_W-1:0]        o_count
);
    import tcaa_pkg::*;

    t_temp                   r_min, n_min;
    t_temp                   r_max, n_max;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    in_range;

    assign in_range = (i_temp != T_UNDER) && (i_temp != T_OVER);

    always_comb begin
        n_min   = r_min;
        n_max   = r_max;
        n_sum   = r_sum;
        n_count = r_count;
        if (i_ctl.clr) begin
            n_min   = MIN_INIT;
            n_max   = MAX_INIT;
            n_sum   = '0;
            n_count = '0;
        end else if (i_ctl.upd) begin
            // sum and count saturate at the group size
            if (in_range && (r_count < CNT_W'(CHANNELS))) begin
                n_count = r_count + CNT_W'(1);
                n_sum   = r_sum + {{(SUM_W-TEMP_W){i_temp[TEMP_W-1]}}, i_temp};
            end
            if (i_temp < r_min) begin
                n_min = i_temp;
            end
            if (i_temp > r_max) begin
                n_max = i_temp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= MIN_INIT;
            r_max   <= MAX_INIT;
            r_sum   <= '0;
            r_count <= '0;
        end else begin
            r_min   <= n_min;
            r_max   <= n_max;
            r_sum   <= n_sum;
            r_count <= n_count;
        end
    end

    assign o_min   = r_min;
    assign o_max   = r_max;
    assign o_sum   = r_sum;
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== rtl/thermistor_convert_and_aggregate_core.sv =====
// Steps: table search tests one point at a time (up to 33), interpolation subtracts the
// span once per degree, the reading is accumulated, a group close adds a snapshot and a
// restoring division (one quotient bit per sum magnitude bit, 10 bits), then output load.
// Throughput: one reading at a time; the next is taken once the result is in the output reg.
// Reset: synchronous active low; clears sequencer, output valid and accumulators
// (min 121, max -121, sum and count 0).
`default_nettype none

module thermistor_convert_and_aggregate_core #(
    parameter int CHANNELS = 7
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcaa_in_if.sink   i_in,
    tcaa_out_if.source o_out
);
    import tcaa_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_W   = $clog2(CHANNELS + 1);
    localparam int SUM_W   = CNT_W + TEMP_W;
    localparam int MAG_W   = SUM_W - 1;
    localparam int DCNT_W  = $clog2(MAG_W);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SRCH = 7'b0000010,
        S_DROP = 7'b0000100,
        S_ACC  = 7'b0001000,
        S_SNAP = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                  r_state, n_state;
    logic [RAW_W-1:0]        r_code, n_code;
    logic                    r_last, n_last;
    logic [IDX_W-1:0]        r_k, n_k;
    logic [ALU_W-1:0]        r_rem, n_rem;
    t_temp                   r_temp, n_temp;
    t_temp                   r_lo, n_lo;
    t_temp                   r_hi, n_hi;
    logic                    r_done, n_done;
    logic                    r_none, n_none;
    logic                    r_neg, n_neg;
    logic [MAG_W-1:0]        r_dvd, n_dvd;
    logic [CNT_W-1:0]        r_part, n_part;
    logic [CNT_W-1:0]        r_den, n_den;
    logic [DCNT_W-1:0]       r_div_cnt, n_div_cnt;

    logic                    r_out_valid, n_out_valid;
    t_temp                   r_o_temp, n_o_temp;
    logic                    r_o_done, n_o_done;
    t_temp                   r_o_lo, n_o_lo;
    t_temp                   r_o_hi, n_o_hi;
    t_temp                   r_o_avg, n_o_avg;
    logic                    r_o_none, n_o_none;

    logic [ALU_W-1:0]        alu_a, alu_b;
    t_alu_res                alu_res;
    logic [CNT_W:0]          div_a;
    t_acc_ctl                acc_ctl;
    t_temp                   acc_min, acc_max;
    logic signed [SUM_W-1:0] acc_sum;
    logic [CNT_W-1:0]        acc_count;
    logic [MAG_W-1:0]        sum_abs;
    t_temp                   quo, avg;
    logic                    out_free;

    tcaa_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    tcaa_acc #(.CHANNELS(CHANNELS)) u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (acc_ctl),
        .i_temp  (r_temp),
        .o_min   (acc_min),
        .o_max   (acc_max),
        .o_sum   (acc_sum),
        .o_count (acc_count)
    );

    assign div_a    = {r_part, r_dvd[MAG_W-1]};
    assign sum_abs  = MAG_W'(acc_sum[SUM_W-1] ? -acc_sum : acc_sum);
    assign quo      = TEMP_W'(r_dvd);
    assign avg      = r_neg ? -quo : quo;
    assign out_free = !r_out_valid || o_out.ready;

    always_comb begin
        alu_a = '0;
        alu_b = '0;
        case (r_state)
            S_SRCH: begin
                alu_a = r_code;
                alu_b = CAL_POINTS[r_k];
            end
            S_DROP: begin
                alu_a = r_rem;
                alu_b = cal_span(r_k);
            end
            S_DIV: begin
                alu_a = ALU_W'(div_a);
                alu_b = ALU_W'(r_den);
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_last      = r_last;
        n_k         = r_k;
        n_rem       = r_rem;
        n_temp      = r_temp;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_done      = r_done;
        n_none      = r_none;
        n_neg       = r_neg;
        n_dvd       = r_dvd;
        n_part      = r_part;
        n_den       = r_den;
        n_div_cnt   = r_div_cnt;
        n_out_valid = r_out_valid;
        n_o_temp    = r_o_temp;
        n_o_done    = r_o_done;
        n_o_lo      = r_o_lo;
        n_o_hi      = r_o_hi;
        n_o_avg     = r_o_avg;
        n_o_none    = r_o_none;
        acc_ctl     = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_code  = i_in.raw_reading;
                    n_last  = i_in.last_channel;
                    n_k     = '0;
                    n_done  = 1'b0;
                    n_state = S_SRCH;
                end
            end
            S_SRCH: begin
                if ((r_k == '0) && alu_res.ge && (alu_res.diff != '0)) begin
                    n_temp  = T_UNDER;
                    n_state = S_ACC;
                end else if (alu_res.diff == '0) begin
                    n_temp  = base_temp(r_k);
                    n_state = S_ACC;
                end else if (alu_res.ge) begin
                    // between points: remainder starts at 5 * offset
                    n_rem   = (alu_res.diff << 2) + alu_res.diff;
                    n_temp  = base_temp(r_k);
                    n_state = S_DROP;
                end else if (r_k == LAST_IDX) begin
                    n_temp  = T_OVER;
                    n_state = S_ACC;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_DROP: begin
                // repeated subtraction of the span, one degree per hit
                if (alu_res.ge) begin
                    n_rem  = alu_res.diff;
                    n_temp = r_temp - t_temp'(1);
                end else begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                acc_ctl.upd = 1'b1;
                n_state     = r_last ? S_SNAP : S_OUT;
            end
            S_SNAP: begin
                acc_ctl.clr = 1'b1;
                n_done      = 1'b1;
                n_lo        = acc_min;
                n_hi        = acc_max;
                n_none      = (acc_count == '0);
                n_neg       = acc_sum[SUM_W-1];
                n_dvd       = sum_abs;
                n_part      = '0;
                n_den       = acc_count;
                n_div_cnt   = DCNT_W'(MAG_W - 1);
                n_state     = (acc_count == '0) ? S_OUT : S_DIV;
            end
            S_DIV: begin
                n_dvd  = {r_dvd[MAG_W-2:0], alu_res.ge};
                n_part = alu_res.ge ? alu_res.diff[CNT_W-1:0] : div_a[CNT_W-1:0];
                if (r_div_cnt == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_div_cnt = r_div_cnt - DCNT_W'(1);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_o_temp    = r_temp;
                    n_o_done    = r_done;
                    n_o_lo      = r_done ? r_lo : t_temp'(0);
                    n_o_hi      = r_done ? r_hi : t_temp'(0);
                    n_o_avg     = r_done ? avg : t_temp'(0);
                    n_o_none    = r_done && r_none;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_code    <= n_code;
        r_last    <= n_last;
        r_k       <= n_k;
        r_rem     <= n_rem;
        r_temp    <= n_temp;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_done    <= n_done;
        r_none    <= n_none;
        r_neg     <= n_neg;
        r_dvd     <= n_dvd;
        r_part    <= n_part;
        r_den     <= n_den;
        r_div_cnt <= n_div_cnt;
        r_o_temp  <= n_o_temp;
        r_o_done  <= n_o_done;
        r_o_lo    <= n_o_lo;
        r_o_hi    <= n_o_hi;
        r_o_avg   <= n_o_avg;
        r_o_none  <= n_o_none;
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.temperature   = r_o_temp;
    assign o_out.group_done    = r_o_done;
    assign o_out.lowest        = r_o_lo;
    assign o_out.highest       = r_o_hi;
    assign o_out.average       = r_o_avg;
    assign o_out.none_in_range = r_o_none;

    `ASSERT_IMPLIES(a_lo_le_hi, i_clk, i_rst_n, o_out.valid && o_out.group_done,
        o_out.lowest <= o_out.highest, "group low above group high")
    `ASSERT_IMPLIES(a_empty_avg, i_clk, i_rst_n, o_out.valid && o_out.none_in_range,
        o_out.average == t_temp'(0), "empty group with nonzero average")
    `ASSERT_IMPLIES(a_avg_range, i_clk, i_rst_n,
        o_out.valid && o_out.group_done && !o_out.none_in_range,
        (o_out.average >= T_BASE) && (o_out.average <= t_temp'(120)), "average out of range")
    `ASSERT_IMPLIES(a_temp_range, i_clk, i_rst_n, o_out.valid,
        (o_out.temperature >= T_UNDER) && (o_out.temperature <= T_OVER),
        "temperature out of range")
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready,
        !i_in.ready, "input taken again before conversion ran")

endmodule

`default_nettype wire

// ===== tb/thermistor_convert_and_aggregate_core_tb.sv =====
// Self-checking testbench for the thermistor converter with per-group low/high/average.
`timescale 1ns / 100ps

module thermistor_convert_and_aggregate_core_tb;
    import tcaa_pkg::*;

    localparam int CHANNELS    = 7;
    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_TARGET = 900;

    typedef struct packed {
        t_temp temperature;
        logic  group_done;
        t_temp lowest;
        t_temp highest;
        t_temp average;
        logic  none_in_range;
    } t_temp_result;

    // Tracks group statistics and holds the temperatures still owed by the block.
    class group_temp_tracker;
        int           grp_min;
        int           grp_max;
        int           grp_sum;
        int           grp_count;
        bit           grp_capped;
        t_temp_result due_temps[$];
        int           errors;
        int           readings_seen;
        int           groups_closed;
        int           empty_groups;
        int           capped_groups;
        int           out_of_range;

        function new();
            clear_group();
        endfunction

        function void clear_group();
            grp_min    = int'(MIN_INIT);
            grp_max    = int'(MAX_INIT);
            grp_sum    = 0;
            grp_count  = 0;
            grp_capped = 0;
        endfunction

        // Table walk with floor interpolation between neighboring points.
        function t_temp to_degrees(logic [RAW_W-1:0] code);
            int c;
            int hi_pt;
            int lo_pt;
            c = int'(code);
            if (c > int'(CAL_POINTS[0])) return T_UNDER;
            if (c < int'(CAL_POINTS[TABLE_ENTRIES-1])) return T_OVER;
            for (int k = 1; k < TABLE_ENTRIES; k++) begin
                hi_pt = int'(CAL_POINTS[k-1]);
                lo_pt = int'(CAL_POINTS[k]);
                if (c >= lo_pt)
                    return t_temp'(int'(T_BASE) + STEP_C * k
                                   - (STEP_C * (c - lo_pt)) / (hi_pt - lo_pt));
            end
            return T_OVER;
        endfunction

        function void note_reading(logic [RAW_W-1:0] raw, logic closes);
            t_temp_result r;
            int           t;
            t = to_degrees(raw);
            readings_seen++;
            r = '0;
            r.temperature = t_temp'(t);
            if (t >= int'(T_BASE) && t < int'(T_OVER)) begin
                if (grp_count < CHANNELS) begin
                    grp_count++;
                    grp_sum += t;
                end else begin
                    grp_capped = 1;
                end
            end else begin
                out_of_range++;
            end
            if (t < grp_min) grp_min = t;
            if (t > grp_max) grp_max = t;
            if (closes) begin
                r.group_done    = 1'b1;
                r.lowest        = t_temp'(grp_min);
                r.highest       = t_temp'(grp_max);
                r.none_in_range = (grp_count == 0);
                r.average       = (grp_count == 0) ? '0 : t_temp'(grp_sum / grp_count);
                groups_closed++;
                if (grp_count == 0) empty_groups++;
                if (grp_capped) capped_groups++;
                clear_group();
            end
            due_temps.push_back(r);
        endfunction

        function string fmt(t_temp_result r);
            return $sformatf("temp=%0d done=%0b low=%0d high=%0d avg=%0d empty=%0b",
                             r.temperature, r.group_done, r.lowest, r.highest,
                             r.average, r.none_in_range);
        endfunction

        function void check_result(t_temp_result got);
            t_temp_result want;
            if (due_temps.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result with nothing outstanding: %s", fmt(got));
                return;
            end
            want = due_temps.pop_front();
            if (got.temperature !== want.temperature || got.group_done !== want.group_done ||
                got.lowest !== want.lowest || got.highest !== want.highest ||
                got.average !== want.average || got.none_in_range !== want.none_in_range) begin
                errors++;
                if (errors <= 10) begin
                    $display("bad result at %0t", $realtime);
                    $display("  expected %s", fmt(want));
                    $display("  actual   %s", fmt(got));
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    tcaa_in_if  reading_ch ();
    tcaa_out_if temp_ch ();

    thermistor_convert_and_aggregate_core #(
        .CHANNELS (CHANNELS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (reading_ch),
        .o_out   (temp_ch)
    );

    group_temp_tracker tracker = new();

    int          burst_left    = 0;
    int          sent_count    = 0;
    int          idle_count    = 0;
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          hold_left     = 0;
    int          mask_age      = 0;
    logic [15:0] stall_mask    = '1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Transaction monitors on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && reading_ch.valid && reading_ch.ready)
            tracker.note_reading(reading_ch.raw_reading, reading_ch.last_channel);
        if (i_rst_n && temp_ch.valid && temp_ch.ready)
            tracker.check_result(t_temp_result'{temp_ch.temperature, temp_ch.group_done,
                                                temp_ch.lowest, temp_ch.highest,
                                                temp_ch.average, temp_ch.none_in_range});
    end

    // Watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (reading_ch.valid && reading_ch.ready) ||
            (temp_ch.valid && temp_ch.ready)) begin
            idle_count <= 0;
        end else if (idle_count >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("thermistor_convert_and_aggregate_core: mismatch");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    // Receiver: rotating stall mask, reloaded every so often, plus requested long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            temp_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            temp_ch.ready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            temp_ch.ready <= 1'b0;
            holds_served  <= hold_requests;
            hold_left     <= HOLD_CYCLES;
        end else begin
            temp_ch.ready <= stall_mask[0];
            if (mask_age == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_mask <= '1;
                    1: stall_mask <= 16'($urandom) | 16'h1;
                    2: stall_mask <= 16'($urandom | $urandom) | 16'h1;
                    default: stall_mask <= 16'($urandom & $urandom) | 16'h1;
                endcase
                mask_age <= $urandom_range(16, 128);
            end else begin
                stall_mask <= {stall_mask[0], stall_mask[15:1]};
                mask_age   <= mask_age - 1;
            end
        end
    end

    function automatic logic [RAW_W-1:0] draw_code();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) return RAW_W'($urandom_range(265, 499));
        if (pick == 6) return RAW_W'($urandom_range(255, 275));
        if (pick == 7) return RAW_W'($urandom_range(490, 510));
        return RAW_W'($urandom_range(0, 1023));
    endfunction

    // Sender works in bursts; between bursts valid may drop for a random gap.
    task automatic offer_reading(input logic [RAW_W-1:0] raw, input logic closes);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                reading_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        reading_ch.valid        <= 1'b1;
        reading_ch.raw_reading  <= raw;
        reading_ch.last_channel <= closes;
        @(posedge i_clk);
        while (!reading_ch.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic drain_results();
        reading_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (tracker.due_temps.size() != 0);
    endtask

    initial begin
        int kind;
        int len;
        bit hold_done;
        bit drain_done;

        hold_done  = 0;
        drain_done = 0;
        i_rst_n                 <= 1'b0;
        reading_ch.valid        <= 1'b0;
        reading_ch.raw_reading  <= '0;
        reading_ch.last_channel <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // over range, under range, both table ends and the code just past the cold end
        offer_reading(10'd0, 1'b0);
        offer_reading(10'd1023, 1'b0);
        offer_reading(10'd499, 1'b0);
        offer_reading(10'd500, 1'b0);
        offer_reading(10'd265, 1'b1);
        // single-channel groups with nothing in range
        offer_reading(10'd264, 1'b1);
        offer_reading(10'd512, 1'b1);
        // negative average truncates toward zero
        offer_reading(10'd497, 1'b0);
        offer_reading(10'd499, 1'b1);
        // interpolated codes
        offer_reading(10'd470, 1'b0);
        offer_reading(10'd400, 1'b0);
        offer_reading(10'd300, 1'b0);
        offer_reading(10'd266, 1'b1);
        // group longer than the channel count: average keeps only the first ones
        for (int i = 0; i < CHANNELS + 2; i++)
            offer_reading(RAW_W'(450 - 10 * i), (i == CHANNELS + 1));
        offer_reading(10'd380, 1'b1);
        drain_results();

        while (sent_count < ITEM_TARGET) begin
            if (!hold_done && sent_count >= 300) begin
                hold_requests <= hold_requests + 1;
                hold_done = 1;
            end
            if ((!drain_done && sent_count >= 600) || $urandom_range(0, 39) == 0) begin
                drain_results();
                drain_done = drain_done || (sent_count >= 600);
            end
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise: raw codes anywhere with random group marks
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    offer_reading(RAW_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
            end else begin
                len = (kind == 1) ? $urandom_range(CHANNELS + 1, CHANNELS + 6)
                                  : $urandom_range(1, CHANNELS);
                for (int i = 0; i < len; i++)
                    offer_reading(draw_code(), (i == len - 1));
            end
        end

        reading_ch.valid <= 1'b0;
        while (tracker.due_temps.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        tracker.errors += tracker.due_temps.size();

        $display("ran %0d readings in %0d groups; %0d readings out of range",
                 tracker.readings_seen, tracker.groups_closed, tracker.out_of_range);
        $display("%0d groups had no in-range channel, %0d ran past the %0d-channel cap",
                 tracker.empty_groups, tracker.capped_groups, CHANNELS);
        if (tracker.errors == 0) begin
            $display("thermistor_convert_and_aggregate_core: match");
        end else begin
            $display("%0d mismatches", tracker.errors);
            $display("thermistor_convert_and_aggregate_core: mismatch");
        end
        $finish;
    end

endmodule
